### src/srmg_pkg.sv
`default_nettype none
package srmg_pkg;

  // number of entries the set can hold
  localparam int SET_DEPTH = 64;

  localparam int ADDR_W  = $clog2(SET_DEPTH);
  localparam int CNT_W   = $clog2(SET_DEPTH + 1);
  localparam int CAP_W   = 7;
  localparam int VAL_W   = 32;
  localparam int SPAN_W  = 32;
  localparam int GAP_W   = 33;
  localparam int OCNT_W  = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the offered value, restart the scan
    logic scan;      // walk the stored values
    logic commit;    // store the value, update count and extremes
    logic load;      // load the result register
    logic reject;    // result reports a full set
  } srmg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_done;
    logic out_free;
  } srmg_sts_t;

endpackage
`default_nettype wire

### src/srmg_if.sv
`default_nettype none
interface srmg_in_if;
  import srmg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface srmg_out_if;
  import srmg_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [OCNT_W-1:0] stored_count;
  logic              spans_valid;
  logic [SPAN_W-1:0] longest_span;
  logic [SPAN_W-1:0] shortest_span;

  modport source (output valid, output status, output stored_count, output spans_valid,
                  output longest_span, output shortest_span, input ready);
  modport sink   (input valid, input status, input stored_count, input spans_valid,
                  input longest_span, input shortest_span, output ready);
endinterface
`default_nettype wire

### src/srmg_ram.sv
`default_nettype none
module srmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/srmg_ctrl.sv
`default_nettype none
module srmg_ctrl
  import srmg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire srmg_sts_t sts,
  output      srmg_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_COMMIT = 6'b001000,
    S_DONE   = 6'b010000,
    S_REJECT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.full ? S_REJECT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REJECT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/srmg_dp.sv
`default_nettype none
module srmg_dp
  import srmg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cap_we,
  input  wire logic [CAP_W-1:0]        cap_wdata,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire srmg_cmd_t               cmd,
  output      srmg_sts_t               sts,
  srmg_out_if.source                   results
);

  logic [CAP_W-1:0]        capacity;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] smallest;
  logic signed [VAL_W-1:0] largest;
  logic [GAP_W-1:0]        min_gap;

  // scan pipeline: read, difference, magnitude, compare
  logic [CNT_W-1:0]        rd_ptr;
  logic                    rd_vld;
  logic                    diff_vld;
  logic                    mag_vld;
  logic signed [VAL_W:0]   diff;
  logic [SPAN_W-1:0]       mag;
  logic [VAL_W-1:0]        rdata;
  logic                    issue;
  logic [VAL_W:0]          diff_neg;
  logic [CMP_W-1:0]        cnt_ext;
  logic                    two_held;

  assign issue    = cmd.scan && (rd_ptr != count);
  assign diff_neg = -diff;
  assign cnt_ext  = CMP_W'(count);
  assign two_held = (count >= CNT_W'(2));

  srmg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SET_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cap_we) begin
      capacity <= cap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value <= in_value;
    end
    diff <= {value[VAL_W-1], value} - {rdata[VAL_W-1], rdata};
    mag  <= diff[VAL_W] ? diff_neg[SPAN_W-1:0] : diff[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      rd_vld   <= 1'b0;
      diff_vld <= 1'b0;
      mag_vld  <= 1'b0;
    end else if (cmd.capture) begin
      rd_ptr   <= '0;
      rd_vld   <= 1'b0;
      diff_vld <= 1'b0;
      mag_vld  <= 1'b0;
    end else begin
      rd_vld   <= issue;
      diff_vld <= rd_vld;
      mag_vld  <= diff_vld;
      if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= '1;
    end else if (mag_vld && ({1'b0, mag} < min_gap)) begin
      min_gap <= {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (count == '0) begin
        smallest <= value;
        largest  <= value;
      end else begin
        if (value < smallest) begin
          smallest <= value;
        end
        if (value > largest) begin
          largest <= value;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      results.status       <= cmd.reject ? STATUS_FULL : STATUS_OK;
      results.stored_count <= cnt_ext[OCNT_W-1:0];
      results.spans_valid  <= two_held;
      results.longest_span <= two_held ? SPAN_W'(largest - smallest) : '0;
      results.shortest_span <= two_held ? min_gap[SPAN_W-1:0] : '0;
    end
  end

  // full when count reaches the capacity or the store depth
  assign sts.full      = (cnt_ext >= CMP_W'(capacity)) || (count == CNT_W'(SET_DEPTH));
  assign sts.scan_done = (rd_ptr == count) && !rd_vld && !diff_vld && !mag_vld;
  assign sts.out_free  = !results.valid || results.ready;

endmodule
`default_nettype wire

### src/set_range_and_min_gap.sv
`default_nettype none
// channel    dir   handshake         payload
// items      in    valid / ready     value (signed 32)
// results    out   valid / ready     status, stored_count, spans_valid,
//                                    longest_span, shortest_span
// capacity   in    cfg_wr_en         cfg_wr_data (7 bits)
//
// add: after accept, check, read each held value, three-stage drain (both skipped
//   when empty), commit, load; next item can be taken the cycle after the load
// rejected add: check, then load; next item can be taken the cycle after the load
// rst is synchronous; sets min gap to all ones, clears count, capacity, result valid
// a result waits in the output register while the next item is taken; the block
//   stalls only when a new result is ready and the old one is not yet taken
module set_range_and_min_gap
  import srmg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  srmg_in_if.sink               items,
  srmg_out_if.source            results
);

  srmg_cmd_t cmd;
  srmg_sts_t sts;
  logic      in_ready;

  // ready is high only while the controller waits for a new item
  assign items.ready = in_ready;

  // sequencer: check, scan, commit, report (or report a full set)
  srmg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // value store, distance pipeline, extremes, gap and result register
  srmg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cap_we    (cfg_wr_en),
    .cap_wdata (cfg_wr_data),
    .in_value  (items.value),
    .cmd       (cmd),
    .sts       (sts),
    .results   (results)
  );

endmodule
`default_nettype wire
